// ----- rtl/mfsgd_pkg.sv -----
// Package for the SGD matrix factorization update unit.
// Holds sizes, command, table and register codes plus Q8.24 helper functions.
// No dependencies.
package mfsgd_pkg;

  localparam int WordW = 32;
  localparam int FracBits = 24;
  localparam int RateW = 25;
  localparam int CountW = 5;
  localparam int SumW = 63;
  localparam int CfgIdxW = 3;

  // Model sizes; indexes wrap on their low bits, so these stay powers of two.
  localparam int MaxRows = 1024;
  localparam int MaxCols = 1024;
  localparam int MaxFactors = 16;

  typedef enum logic [1:0] {
    CMD_TRAIN = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_ROW_BIAS = 2'd0,
    SEL_ROW_FACT = 2'd1,
    SEL_COL_BIAS = 2'd2,
    SEL_COL_FACT = 2'd3
  } sel_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEARN_RATE   = 3'd0,
    REG_BIAS_DECAY   = 3'd1,
    REG_FACTOR_DECAY = 3'd2,
    REG_MEAN_RATING  = 3'd3,
    REG_FACTOR_COUNT = 3'd4
  } reg_idx_t;

  // Saturate a signed 64-bit value to 32 bits.
  function automatic logic signed [WordW-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (x > hi) sat32 = 32'sh7FFF_FFFF;
    else if (x < lo) sat32 = 32'sh8000_0000;
    else sat32 = x[WordW-1:0];
  endfunction

  // Saturating add onto a 63-bit sum.
  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] acc,
                                              input logic [SumW-1:0] add);
    logic [SumW:0] s;
    s = {1'b0, acc} + {1'b0, add};
    sat_add = s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

endpackage

// ----- rtl/sgd_matrix_factorization_update_unit.sv -----
// Top level of the SGD matrix factorization update unit.
// Uses mfsgd_pkg; holds four model memories and a single shared multiplier.
//
// One word is taken at a time. A write, read or clear word passes through the
// S_ACC and S_RES states before its result is loaded into the output register,
// and the next word can be taken once the sequencer is back in S_IDLE. A train
// word first forms the bias sums and the dot product, one pass per factor in
// use, then the residual, the error sums and both bias steps, then for each
// factor in use the read-modify-write of one entry in the row and the column
// factor memories, all through one 33x33 multiplier whose product is
// registered. A result that waits on the output does not block the next word;
// the sequencer holds in its last state until the output register is free. The
// memories hold no reset value; the host loads them before training.
module sgd_matrix_factorization_update_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic [9:0]                        in_row_index,
  input  logic [9:0]                        in_col_index,
  input  logic [3:0]                        in_factor_index,
  input  logic [1:0]                        in_table_select,
  input  logic signed [31:0]                in_data_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_residual,
  output logic signed [31:0]                out_read_word,
  output logic [mfsgd_pkg::SumW-1:0]        out_abs_error_total,
  output logic [mfsgd_pkg::SumW-1:0]        out_sq_error_total,
  input  logic                              cfg_write,
  input  logic [mfsgd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import mfsgd_pkg::*;

  localparam int RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int FacW = (MaxFactors > 1) ? $clog2(MaxFactors) : 1;
  localparam int FcW  = $clog2(MaxFactors + 1);

  typedef enum logic [5:0] {
    S_IDLE, S_ACC, S_RB, S_CB, S_RES, S_SQ, S_SQW,
    S_BDR, S_BDRW, S_BDC, S_BDCW, S_BSTR, S_BSTRW, S_BSTC, S_BSTCW,
    S_FRD, S_FLOAD, S_FDOT, S_FDOTW,
    S_URD, S_UL, S_U1, S_U1W, S_U2, S_U2W, S_U3, S_U3W,
    S_V1, S_V1W, S_V2, S_V2W, S_V3, S_V3W
  } state_t;

  // Model memories.
  logic signed [WordW-1:0] rb_mem [MaxRows];
  logic signed [WordW-1:0] cb_mem [MaxCols];
  logic signed [WordW-1:0] rf_mem [MaxRows*MaxFactors];
  logic signed [WordW-1:0] cf_mem [MaxCols*MaxFactors];

  logic [RowW+FacW-1:0] rf_addr;
  logic [ColW+FacW-1:0] cf_addr;
  logic                 rb_we, cb_we, rf_we, cf_we;
  logic signed [WordW-1:0] rb_wd, cb_wd, rf_wd, cf_wd;
  logic signed [WordW-1:0] rb_q, cb_q, rf_q, cf_q;

  // Configuration registers.
  logic [RateW-1:0]        learn_rate_r, bias_decay_r, factor_decay_r;
  logic signed [WordW-1:0] mean_rating_r;
  logic [CountW-1:0]       factor_count_r;

  // Control and datapath registers.
  state_t                  state_r;
  logic [1:0]              cmd_r, sel_r;
  logic [RowW-1:0]         row_r;
  logic [ColW-1:0]         col_r;
  logic [FacW-1:0]         fi_r, k_r;
  logic [FcW-1:0]          nf_r;
  logic signed [WordW-1:0] data_r;
  logic signed [63:0]      acc_r;
  logic signed [WordW-1:0] resid_r, rb_r, cb_r, u_r, v_r, rd_r;
  logic signed [63:0]      t_r;
  logic signed [65:0]      prod_r;
  logic [SumW-1:0]         abs_r, sq_r;
  logic [SumW-1:0]         abs_nxt;
  logic [WordW:0]          abs_res;
  logic                    res_load;

  // Shared multiplier: 33x33 signed, product registered.
  logic signed [32:0] ma, mb;
  logic signed [63:0] prod_sh;
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end
  assign prod_sh = {{22{prod_r[65]}}, prod_r[65:FracBits]};

  // Operand select per state.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r) inside
      S_SQ:   begin ma = 33'(resid_r); mb = 33'(resid_r); end
      S_BDR:  begin ma = {8'd0, bias_decay_r}; mb = 33'(rb_r); end
      S_BDC:  begin ma = {8'd0, bias_decay_r}; mb = 33'(cb_r); end
      S_BSTR, S_BSTC, S_U3, S_V3: begin
        ma = {8'd0, learn_rate_r}; mb = 33'(sat32(t_r));
      end
      S_FDOT: begin ma = 33'(rf_q); mb = 33'(cf_q); end
      S_U1:   begin ma = 33'(resid_r); mb = 33'(v_r); end
      S_U2:   begin ma = {8'd0, factor_decay_r}; mb = 33'(u_r); end
      S_V1:   begin ma = 33'(resid_r); mb = 33'(u_r); end
      S_V2:   begin ma = {8'd0, factor_decay_r}; mb = 33'(v_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Memory read address and write control.
  assign rf_addr = (state_r == S_IDLE) ? {in_row_index[RowW-1:0], in_factor_index[FacW-1:0]}
                 : (cmd_r == CMD_TRAIN) ? {row_r, k_r} : {row_r, fi_r};
  assign cf_addr = (state_r == S_IDLE) ? {in_col_index[ColW-1:0], in_factor_index[FacW-1:0]}
                 : (cmd_r == CMD_TRAIN) ? {col_r, k_r} : {col_r, fi_r};

  always_comb begin
    rb_we = 1'b0; cb_we = 1'b0; rf_we = 1'b0; cf_we = 1'b0;
    rb_wd = data_r; cb_wd = data_r; rf_wd = data_r; cf_wd = data_r;
    if (state_r == S_ACC && cmd_r == CMD_WRITE) begin
      rb_we = (sel_r == SEL_ROW_BIAS);
      rf_we = (sel_r == SEL_ROW_FACT);
      cb_we = (sel_r == SEL_COL_BIAS);
      cf_we = (sel_r == SEL_COL_FACT);
    end
    if (state_r == S_BSTRW) begin
      rb_we = 1'b1; rb_wd = sat32(64'(rb_r) + prod_sh);
    end
    if (state_r == S_BSTCW) begin
      cb_we = 1'b1; cb_wd = sat32(64'(cb_r) + prod_sh);
    end
    if (state_r == S_U3W) begin
      rf_we = 1'b1; rf_wd = sat32(64'(u_r) + prod_sh);
    end
    if (state_r == S_V3W) begin
      cf_we = 1'b1; cf_wd = sat32(64'(v_r) + prod_sh);
    end
  end

  // Memories: one port each, registered read.
  always_ff @(posedge clk) begin
    if (rb_we) rb_mem[row_r] <= rb_wd;
    rb_q <= rb_mem[(state_r == S_IDLE) ? in_row_index[RowW-1:0] : row_r];
    if (cb_we) cb_mem[col_r] <= cb_wd;
    cb_q <= cb_mem[(state_r == S_IDLE) ? in_col_index[ColW-1:0] : col_r];
    if (rf_we) rf_mem[rf_addr] <= rf_wd;
    rf_q <= rf_mem[rf_addr];
    if (cf_we) cf_mem[cf_addr] <= cf_wd;
    cf_q <= cf_mem[cf_addr];
  end

  assign in_stall = (state_r != S_IDLE);
  assign abs_res  = resid_r[WordW-1] ? 33'(-34'(resid_r)) : {1'b0, resid_r};
  assign abs_nxt  = sat_add(abs_r, SumW'(abs_res));
  // Load the output register once it is empty or being taken.
  assign res_load = (state_r == S_RES) && (!out_valid || !out_stall);

  // Sequencer and registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid      <= 1'b0;
      abs_r          <= '0;
      sq_r           <= '0;
      learn_rate_r   <= RateW'(16777);
      bias_decay_r   <= RateW'(167772);
      factor_decay_r <= RateW'(167772);
      mean_rating_r  <= '0;
      factor_count_r <= CountW'(16);
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_LEARN_RATE:   learn_rate_r   <= cfg_data[RateW-1:0];
          REG_BIAS_DECAY:   bias_decay_r   <= cfg_data[RateW-1:0];
          REG_FACTOR_DECAY: factor_decay_r <= cfg_data[RateW-1:0];
          REG_MEAN_RATING:  mean_rating_r  <= cfg_data;
          REG_FACTOR_COUNT: factor_count_r <= cfg_data[CountW-1:0];
          default: ;
        endcase
      end
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= in_command;
            sel_r  <= in_table_select;
            row_r  <= in_row_index[RowW-1:0];
            col_r  <= in_col_index[ColW-1:0];
            fi_r   <= in_factor_index[FacW-1:0];
            data_r <= in_data_word;
            k_r    <= '0;
            nf_r   <= (32'(factor_count_r) > MaxFactors) ? FcW'(MaxFactors)
                                                         : FcW'(factor_count_r);
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          unique case (cmd_r)
            CMD_TRAIN: begin
              rd_r    <= '0;
              acc_r   <= 64'(data_r) - 64'(mean_rating_r);
              state_r <= S_RB;
            end
            CMD_WRITE: begin
              rd_r    <= '0;
              state_r <= S_RES;
            end
            CMD_READ: begin
              unique case (sel_r)
                SEL_ROW_BIAS: rd_r <= rb_q;
                SEL_ROW_FACT: rd_r <= rf_q;
                SEL_COL_BIAS: rd_r <= cb_q;
                default:      rd_r <= cf_q;
              endcase
              state_r <= S_RES;
            end
            default: begin
              rd_r  <= '0;
              abs_r <= '0; sq_r <= '0;
              state_r <= S_RES;
            end
          endcase
        end
        S_RB: begin
          rb_r  <= rb_q; cb_r <= cb_q;
          acc_r <= acc_r - 64'(rb_q) - 64'(cb_q);
          state_r <= (nf_r == 0) ? S_CB : S_FRD;
        end
        // Dot product: one factor per pass.
        S_FRD:   state_r <= S_FLOAD;
        S_FLOAD: state_r <= S_FDOT;
        S_FDOT:  state_r <= S_FDOTW;
        S_FDOTW: begin
          acc_r <= acc_r - prod_sh;
          if (FcW'(k_r) + 1'b1 == nf_r) begin
            k_r <= '0;
            state_r <= S_CB;
          end else begin
            k_r <= k_r + 1'b1;
            state_r <= S_FRD;
          end
        end
        S_CB: begin
          resid_r <= sat32(acc_r);
          state_r <= S_SQ;
        end
        S_SQ: begin
          abs_r   <= abs_nxt;
          state_r <= S_SQW;
        end
        S_SQW: begin
          sq_r    <= sat_add(sq_r, prod_sh[SumW-1:0]);
          state_r <= S_BDR;
        end
        S_BDR:  state_r <= S_BDRW;
        S_BDRW: begin t_r <= 64'(resid_r) - prod_sh; state_r <= S_BSTR; end
        S_BSTR: state_r <= S_BSTRW;
        S_BSTRW: state_r <= S_BDC;
        S_BDC:  state_r <= S_BDCW;
        S_BDCW: begin t_r <= 64'(resid_r) - prod_sh; state_r <= S_BSTC; end
        S_BSTC: state_r <= S_BSTCW;
        S_BSTCW: state_r <= (nf_r == 0) ? S_RES : S_URD;
        // Factor update: read u_k, v_k, step u_k, then step v_k from the old u_k.
        S_URD: state_r <= S_UL;
        S_UL: begin u_r <= rf_q; v_r <= cf_q; state_r <= S_U1; end
        S_U1:  state_r <= S_U1W;
        S_U1W: begin t_r <= prod_sh; state_r <= S_U2; end
        S_U2:  state_r <= S_U2W;
        S_U2W: begin t_r <= t_r - prod_sh; state_r <= S_U3; end
        S_U3:  state_r <= S_U3W;
        S_U3W: state_r <= S_V1;
        S_V1:  state_r <= S_V1W;
        S_V1W: begin t_r <= prod_sh; state_r <= S_V2; end
        S_V2:  state_r <= S_V2W;
        S_V2W: begin t_r <= t_r - prod_sh; state_r <= S_V3; end
        S_V3:  state_r <= S_V3W;
        S_V3W: begin
          if (FcW'(k_r) + 1'b1 == nf_r) begin
            k_r <= '0;
            state_r <= S_RES;
          end else begin
            k_r <= k_r + 1'b1;
            state_r <= S_URD;
          end
        end
        S_RES: begin
          if (res_load) begin
            out_residual        <= (cmd_r == CMD_TRAIN) ? resid_r : '0;
            out_read_word       <= rd_r;
            out_abs_error_total <= abs_r;
            out_sq_error_total  <= sq_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_residual) && $stable(out_read_word)
      && $stable(out_abs_error_total) && $stable(out_sq_error_total)))
    else $error("result word changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ACC))
    else $error("accepted word not started");
endmodule

// ----- dv/sgd_matrix_factorization_update_unit_tb.sv -----
// Testbench for the SGD matrix factorization update unit: predicts every result word.
// It loads the model, runs directed and random commands under random stalls,
// and checks each result against its own Q8.24 predictor. Depends on mfsgd_pkg.
module sgd_matrix_factorization_update_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfsgd_pkg::*;

  localparam int NRows = 1024;
  localparam int NCols = 1024;
  localparam int NFact = 16;
  localparam int TrainSpan = 8;
  localparam int Drain = 150;
  localparam int CycleLimit = 1000000;
  localparam longint unsigned SumCap = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    cmd_t              cmd;
    logic [9:0]        row;
    logic [9:0]        col;
    logic [3:0]        fi;
    sel_t              sel;
    logic signed [31:0] data;
  } mf_word_t;

  typedef struct {
    logic signed [31:0] residual;
    logic signed [31:0] read_word;
    logic [SumW-1:0]    abs_total;
    logic [SumW-1:0]    sq_total;
  } mf_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [9:0] in_row_index = '0;
  logic [9:0] in_col_index = '0;
  logic [3:0] in_factor_index = '0;
  logic [1:0] in_table_select = '0;
  logic signed [31:0] in_data_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_residual;
  logic signed [31:0] out_read_word;
  logic [SumW-1:0] out_abs_error_total;
  logic [SumW-1:0] out_sq_error_total;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sgd_matrix_factorization_update_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: model tables, error sums and register copies
  logic signed [31:0] row_bias [NRows];
  logic signed [31:0] col_bias [NCols];
  logic signed [31:0] row_fact [NRows][NFact];
  logic signed [31:0] col_fact [NCols][NFact];
  logic [63:0] abs_sum;
  logic [63:0] sq_sum;
  logic [24:0] learn_rate;
  logic [24:0] bias_decay;
  logic [24:0] factor_decay;
  logic signed [31:0] mean_rating;
  logic [4:0] factor_count;

  mf_word_t pending_words[$];
  mf_result_t due_results[$];
  mf_word_t loaded_words[$];
  mf_word_t cur;
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;
  bit hold_used = 1'b0;
  bit hold_go = 1'b0;
  bit quiet = 1'b0;
  int cycles = 0;

  function automatic longint fshift(longint x);
    return x >>> FracBits;
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [63:0] sum_add(logic [63:0] acc, logic [63:0] add);
    if (add > SumCap - acc) return SumCap;
    return acc + add;
  endfunction

  // One gradient step on a word
  function automatic logic signed [31:0] descend(logic signed [31:0] w, longint grad);
    longint g;
    longint lr;
    longint wl;
    g = longint'(clip32(grad));
    lr = longint'(learn_rate);
    wl = longint'(w);
    return clip32(wl + fshift(lr * g));
  endfunction

  // Apply one command word to the model and return its result
  function automatic mf_result_t mf_apply(mf_word_t w);
    mf_result_t res;
    longint acc;
    longint r;
    longint rb;
    longint cb;
    longint bd;
    longint fd;
    longint uk;
    longint vk;
    logic signed [31:0] uold [NFact];
    int nf;
    res.residual = '0;
    res.read_word = '0;
    case (w.cmd)
      CMD_TRAIN: begin
        nf = (factor_count > NFact) ? NFact : int'(factor_count);
        rb = longint'(row_bias[w.row]);
        cb = longint'(col_bias[w.col]);
        bd = longint'(bias_decay);
        fd = longint'(factor_decay);
        acc = longint'(w.data) - longint'(mean_rating) - rb - cb;
        for (int k = 0; k < nf; k++) begin
          uold[k] = row_fact[w.row][k];
          uk = longint'(uold[k]);
          vk = longint'(col_fact[w.col][k]);
          acc -= fshift(uk * vk);
        end
        res.residual = clip32(acc);
        r = longint'(res.residual);
        abs_sum = sum_add(abs_sum, (r < 0) ? -r : r);
        sq_sum = sum_add(sq_sum, fshift(r * r));
        row_bias[w.row] = descend(32'(rb), r - fshift(bd * rb));
        col_bias[w.col] = descend(32'(cb), r - fshift(bd * cb));
        for (int k = 0; k < nf; k++) begin
          uk = longint'(uold[k]);
          vk = longint'(col_fact[w.col][k]);
          row_fact[w.row][k] = descend(uold[k], fshift(r * vk) - fshift(fd * uk));
        end
        for (int k = 0; k < nf; k++) begin
          uk = longint'(uold[k]);
          vk = longint'(col_fact[w.col][k]);
          col_fact[w.col][k] = descend(col_fact[w.col][k], fshift(r * uk) - fshift(fd * vk));
        end
      end
      CMD_WRITE, CMD_READ: begin
        case (w.sel)
          SEL_ROW_BIAS: if (w.cmd == CMD_WRITE) row_bias[w.row] = w.data;
                        else res.read_word = row_bias[w.row];
          SEL_ROW_FACT: if (w.cmd == CMD_WRITE) row_fact[w.row][w.fi] = w.data;
                        else res.read_word = row_fact[w.row][w.fi];
          SEL_COL_BIAS: if (w.cmd == CMD_WRITE) col_bias[w.col] = w.data;
                        else res.read_word = col_bias[w.col];
          default:      if (w.cmd == CMD_WRITE) col_fact[w.col][w.fi] = w.data;
                        else res.read_word = col_fact[w.col][w.fi];
        endcase
      end
      default: begin
        abs_sum = '0;
        sq_sum = '0;
      end
    endcase
    res.abs_total = abs_sum[SumW-1:0];
    res.sq_total = sq_sum[SumW-1:0];
    return res;
  endfunction

  function automatic mf_word_t mk(cmd_t c, int row, int col, int fi, sel_t s,
                                  logic signed [31:0] d);
    mf_word_t w;
    w.cmd = c;
    w.row = 10'(row);
    w.col = 10'(col);
    w.fi = 4'(fi);
    w.sel = s;
    w.data = d;
    return w;
  endfunction

  function automatic logic signed [31:0] small_val(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Driver: offer queued words, predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(mf_apply(cur));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur = pending_words.pop_front();
          in_command <= cur.cmd;
          in_row_index <= cur.row;
          in_col_index <= cur.col;
          in_factor_index <= cur.fi;
          in_table_select <= cur.sel;
          in_data_word <= cur.data;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted result words, drive random and long stalls
  always @(posedge clk) begin
    mf_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          e = due_results.pop_front();
          if (out_residual !== e.residual) begin
            $error("residual: expected %0d actual %0d", e.residual, out_residual);
            errors++;
          end
          if (out_read_word !== e.read_word) begin
            $error("read_word: expected %0d actual %0d", e.read_word, out_read_word);
            errors++;
          end
          if (out_abs_error_total !== e.abs_total) begin
            $error("abs_error_total: expected %0d actual %0d", e.abs_total,
                   out_abs_error_total);
            errors++;
          end
          if (out_sq_error_total !== e.sq_total) begin
            $error("sq_error_total: expected %0d actual %0d", e.sq_total,
                   out_sq_error_total);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (hold_go && !hold_used) begin
        hold_used <= 1'b1;
        hold_cnt <= 400;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hard limit on run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Wait until every word is sent and answered, then let the block settle
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || due_results.size() > 0)
      @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LEARN_RATE:   learn_rate = val[24:0];
      REG_BIAS_DECAY:   bias_decay = val[24:0];
      REG_FACTOR_DECAY: factor_decay = val[24:0];
      REG_MEAN_RATING:  mean_rating = val;
      default:          factor_count = val[4:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_all(int lr, int bd, int fd, logic [31:0] mean, int fc);
    set_reg(REG_LEARN_RATE, lr);
    set_reg(REG_BIAS_DECAY, bd);
    set_reg(REG_FACTOR_DECAY, fd);
    set_reg(REG_MEAN_RATING, mean);
    set_reg(REG_FACTOR_COUNT, fc);
  endtask

  // Random words: mostly training on the loaded block, plus writes, reads, clears
  task automatic queue_random(int n);
    mf_word_t w;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        w = mk(CMD_TRAIN, $urandom_range(0, TrainSpan - 1), $urandom_range(0, TrainSpan - 1),
               $urandom_range(0, 15), sel_t'($urandom_range(0, 3)),
               ($urandom_range(0, 9) == 0) ? $signed($urandom) : small_val(1 << 26));
      end else if (pick < 65) begin
        w = mk(CMD_WRITE, $urandom_range(0, TrainSpan - 1), $urandom_range(0, TrainSpan - 1),
               $urandom_range(0, 15), sel_t'($urandom_range(0, 3)), small_val(1 << 24));
      end else if (pick < 72) begin
        w = mk(CMD_WRITE, $urandom_range(0, NRows - 1), $urandom_range(0, NCols - 1),
               $urandom_range(0, 15), sel_t'($urandom_range(0, 3)), $signed($urandom));
        loaded_words.push_back(w);
      end else if (pick < 85) begin
        w = mk(CMD_READ, $urandom_range(0, TrainSpan - 1), $urandom_range(0, TrainSpan - 1),
               $urandom_range(0, 15), sel_t'($urandom_range(0, 3)), $signed($urandom));
      end else if (pick < 95 && loaded_words.size() > 0) begin
        w = loaded_words[$urandom_range(0, loaded_words.size() - 1)];
        w.cmd = CMD_READ;
      end else begin
        w = mk(CMD_CLEAR, $urandom_range(0, NRows - 1), $urandom_range(0, NCols - 1),
               $urandom_range(0, 15), sel_t'($urandom_range(0, 3)), $signed($urandom));
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    abs_sum = '0;
    sq_sum = '0;
    learn_rate = 25'd16777;
    bias_decay = 25'd167772;
    factor_decay = 25'd167772;
    mean_rating = '0;
    factor_count = 5'd16;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load biases and factors of the training block
    for (int i = 0; i < TrainSpan; i++) begin
      pending_words.push_back(mk(CMD_WRITE, i, 0, 0, SEL_ROW_BIAS, small_val(1 << 24)));
      pending_words.push_back(mk(CMD_WRITE, 0, i, 0, SEL_COL_BIAS, small_val(1 << 24)));
      for (int k = 0; k < NFact; k++) begin
        pending_words.push_back(mk(CMD_WRITE, i, 0, k, SEL_ROW_FACT, small_val(1 << 23)));
        pending_words.push_back(mk(CMD_WRITE, 0, i, k, SEL_COL_FACT, small_val(1 << 23)));
      end
    end
    drain();

    // Directed: extreme words at the far corners, read back, saturating train, clear
    pending_words.push_back(mk(CMD_WRITE, 1023, 0, 15, SEL_ROW_FACT, 32'sh7FFF_FFFF));
    pending_words.push_back(mk(CMD_WRITE, 0, 1023, 15, SEL_COL_FACT, 32'sh8000_0000));
    pending_words.push_back(mk(CMD_WRITE, 1023, 0, 0, SEL_ROW_BIAS, 32'sh8000_0000));
    pending_words.push_back(mk(CMD_WRITE, 0, 1023, 0, SEL_COL_BIAS, 32'sh7FFF_FFFF));
    pending_words.push_back(mk(CMD_READ, 1023, 0, 15, SEL_ROW_FACT, 0));
    pending_words.push_back(mk(CMD_READ, 0, 1023, 15, SEL_COL_FACT, 0));
    pending_words.push_back(mk(CMD_READ, 1023, 0, 0, SEL_ROW_BIAS, 0));
    pending_words.push_back(mk(CMD_READ, 0, 1023, 0, SEL_COL_BIAS, 0));
    pending_words.push_back(mk(CMD_TRAIN, 0, 0, 0, SEL_ROW_BIAS, 32'sh7FFF_FFFF));
    pending_words.push_back(mk(CMD_TRAIN, 1, 1, 0, SEL_ROW_BIAS, 32'sh8000_0000));
    pending_words.push_back(mk(CMD_TRAIN, 2, 3, 0, SEL_ROW_BIAS, 0));
    pending_words.push_back(mk(CMD_WRITE, 4, 0, 0, SEL_ROW_BIAS, 32'sh8000_0000));
    pending_words.push_back(mk(CMD_TRAIN, 4, 4, 0, SEL_ROW_BIAS, 32'sh7FFF_FFFF));
    pending_words.push_back(mk(CMD_READ, 4, 0, 0, SEL_ROW_BIAS, 0));
    pending_words.push_back(mk(CMD_CLEAR, 0, 0, 0, SEL_ROW_BIAS, 0));
    pending_words.push_back(mk(CMD_TRAIN, 5, 6, 0, SEL_ROW_BIAS, 32'sh0100_0000));
    pending_words.push_back(mk(CMD_READ, 5, 6, 7, SEL_ROW_FACT, 0));
    pending_words.push_back(mk(CMD_READ, 5, 6, 7, SEL_COL_FACT, 0));
    drain();

    // Default registers, with one long receiver hold so the input backs up
    hold_go = 1'b1;
    queue_random(60);
    drain();

    // Step of 1.0, no decay, top mean, one factor
    set_all(16777216, 0, 0, 32'h7FFF_FFFF, 1);
    queue_random(30);
    drain();

    // Zero step, decay of 1.0, bottom mean, no factors
    set_all(0, 16777216, 16777216, 32'h8000_0000, 0);
    queue_random(30);
    drain();

    // Factor count above the maximum saturates
    set_all(1 << 20, 1 << 18, 1 << 19, small_val(1 << 26), 31);
    queue_random(40);
    drain();

    // Last stretch without idling on either side
    set_all(16777, 167772, 167772, 32'h0080_0000, 5);
    quiet = 1'b1;
    queue_random(50);
    drain();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
